[design/icpm_pkg.sv]
// Package for the input capture period meter: codes, records and defaults.
`timescale 1ns / 1ps

package icpm_pkg;

  // Default sizes handed to the top level
  localparam int DEF_CHANNELS    = 4;
  localparam int DEF_COUNT_WIDTH = 32;

  // Reload register reset: all ones, free 32-bit wrap
  localparam logic [31:0] RELOAD_RESET = 32'hFFFF_FFFF;

  // Request kinds
  typedef enum logic [1:0] {
    ACT_TICK    = 2'd0,
    ACT_CAPTURE = 2'd1,
    ACT_CLEAR   = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  // One input request as held in the input register
  typedef struct packed {
    action_t     action;
    logic [1:0]  channel;
    logic [31:0] capture_value;
    logic        overcapture;
    logic        overflow_pending;
    logic [31:0] counter_now;
    logic [31:0] time_ms;
  } item_t;

  // Stored state of the addressed channel
  typedef struct packed {
    logic        seen;
    logic        valid;
    logic [31:0] last_count;
    logic [31:0] last_overflow;
    logic [31:0] period;
  } chan_rec_t;

  // Update decided by the distance logic
  typedef struct packed {
    logic        lost;       // overcapture drops the channel marks
    logic        store_cap;  // capture and stamp are written
    logic        fresh;      // a usable period was found
    logic [31:0] cap;
    logic [31:0] ov;
    logic [31:0] delta;
  } dist_t;

  // One result item
  typedef struct packed {
    logic [1:0]  channel_out;
    logic        new_period;
    logic [31:0] period_ticks;
    logic        channel_valid;
    logic        capture_lost;
  } res_t;

endpackage

[design/icpm_dist.sv]
// Overflow stamp correction and tick distance for one capture request.
`timescale 1ns / 1ps

module icpm_dist #(
  parameter int COUNT_WIDTH = icpm_pkg::DEF_COUNT_WIDTH
) (
  input  logic [31:0]          reload,
  input  logic [31:0]          ovf_total,
  input  icpm_pkg::item_t      item,
  input  logic                 in_range,
  input  icpm_pkg::chan_rec_t  rec,
  output icpm_pkg::dist_t      upd
);

  localparam logic [31:0] CountMask = 32'((64'd1 << COUNT_WIDTH) - 64'd1);

  logic [31:0] cap;
  logic [31:0] now;
  logic [31:0] rl;
  logic        free_wrap;
  logic [31:0] period;
  logic [31:0] half;
  logic [31:0] ov;
  logic [31:0] ovd;
  logic        ge;
  logic [31:0] mul_a;
  logic [63:0] prod;
  logic [32:0] addend;
  logic [64:0] sum;
  logic        d_ok;
  logic [31:0] delta;
  logic        is_cap;

  assign cap       = item.capture_value & CountMask;
  assign now       = item.counter_now & CountMask;
  assign rl        = reload & CountMask;
  assign free_wrap = (rl == 32'hFFFF_FFFF);
  assign period    = rl + 32'd1;
  assign half      = period >> 1;

  // Stamp correction for an edge close to the counter wrap
  always_comb begin
    ov = ovf_total;
    if (!free_wrap) begin
      if (item.overflow_pending) begin
        if (cap < half) ov = ovf_total + 32'd1;
      end else if ((ovf_total != 32'd0) && (now < half) && (cap > half)) begin
        ov = ovf_total - 32'd1;
      end
    end
  end

  // Distance: whole periods times period plus the partial span
  assign ovd    = ov - rec.last_overflow;
  assign ge     = (cap >= rec.last_count);
  assign mul_a  = ge ? ovd : (ovd - 32'd1);
  assign prod   = 64'(mul_a) * 64'(period);
  assign addend = ge ? {1'b0, cap - rec.last_count}
                     : ({1'b0, period - rec.last_count} + {1'b0, cap});
  assign sum    = {1'b0, prod} + {32'd0, addend};

  always_comb begin
    if (free_wrap) begin
      delta = cap - rec.last_count;
      d_ok  = (cap != rec.last_count);
    end else if (ge || (ovd != 32'd0)) begin
      delta = sum[31:0];
      d_ok  = (sum != 65'd0) && (sum[64:32] == 33'd0);
    end else begin
      delta = sum[31:0];
      d_ok  = 1'b0;
    end
  end

  // Decide the channel update
  assign is_cap        = (item.action == icpm_pkg::ACT_CAPTURE) && in_range;
  assign upd.lost      = is_cap && item.overcapture;
  assign upd.store_cap = is_cap && !item.overcapture;
  assign upd.fresh     = is_cap && !item.overcapture && rec.seen && d_ok;
  assign upd.cap       = cap;
  assign upd.ov        = ov;
  assign upd.delta     = delta;

endmodule

[design/icpm_state.sv]
// Overflow count and per-channel capture state, with the result of each request.
`timescale 1ns / 1ps

module icpm_state #(
  parameter int CHANNELS = icpm_pkg::DEF_CHANNELS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 go,
  input  icpm_pkg::item_t      item,
  input  icpm_pkg::dist_t      upd,
  output logic                 in_range,
  output logic [31:0]          ovf_total,
  output icpm_pkg::chan_rec_t  rec,
  output icpm_pkg::res_t       res
);

  localparam int ChIdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic        seen          [CHANNELS];
  logic        valid         [CHANNELS];
  logic [31:0] last_count    [CHANNELS];
  logic [31:0] last_overflow [CHANNELS];
  logic [31:0] period_store  [CHANNELS];
  logic [31:0] period_time   [CHANNELS];
  logic [31:0] overflow_total;

  logic [ChIdxW-1:0] idx;
  logic              is_clear;

  assign in_range  = ({1'b0, item.channel} < 3'(CHANNELS));
  assign idx       = item.channel[ChIdxW-1:0];
  assign is_clear  = (item.action == icpm_pkg::ACT_CLEAR);
  assign ovf_total = overflow_total;

  // Read the addressed channel
  always_comb begin
    rec = '0;
    if (in_range) begin
      rec.seen          = seen[idx];
      rec.valid         = valid[idx];
      rec.last_count    = last_count[idx];
      rec.last_overflow = last_overflow[idx];
      rec.period        = period_store[idx];
    end
  end

  // State update, one request per cycle on which go is high
  always_ff @(posedge clk) begin
    if (rst || (go && is_clear)) begin
      overflow_total <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        seen[i]          <= 1'b0;
        valid[i]         <= 1'b0;
        last_count[i]    <= '0;
        last_overflow[i] <= '0;
        period_store[i]  <= '0;
        period_time[i]   <= '0;
      end
    end else if (go) begin
      if (item.action == icpm_pkg::ACT_TICK) begin
        overflow_total <= overflow_total + 32'd1;
      end
      if (upd.lost) begin
        seen[idx]  <= 1'b0;
        valid[idx] <= 1'b0;
      end
      if (upd.store_cap) begin
        seen[idx]          <= 1'b1;
        last_count[idx]    <= upd.cap;
        last_overflow[idx] <= upd.ov;
      end
      if (upd.fresh) begin
        valid[idx]        <= 1'b1;
        period_store[idx] <= upd.delta;
        period_time[idx]  <= item.time_ms;
      end
    end
  end

  // Result fields as they stand after the request
  always_comb begin
    res               = '0;
    res.channel_out   = item.channel;
    res.new_period    = upd.fresh;
    res.capture_lost  = upd.lost;
    if (in_range && !is_clear) begin
      res.period_ticks  = upd.fresh ? upd.delta : rec.period;
      res.channel_valid = upd.fresh || (rec.valid && !upd.lost);
    end
  end

endmodule

[design/input_capture_period_meter.sv]
// Top level of the input capture period meter: registers, handshakes, checks.
//
//  channel     | group         | contents (low bit first)
//  ------------+---------------+----------------------------------------------------
//  request in  | s_axis_*      | tuser: action, channel; tdata: capture_value,
//              |               |   overcapture, overflow_pending, counter_now, time_ms
//  result out  | m_axis_*      | tuser: channel_out; tdata: new_period, period_ticks,
//              |               |   channel_valid, capture_lost
//  reload reg  | cfg_we/wdata  | auto-reload setting, write only
//
// One request per cycle sustained while m_axis_tready does not hold a result; a
// request passes the input register, then the result register. The cycle is set by
// the channel read, the 32x32 multiply with its add and range check, and write-back.
// rst is synchronous: all state clears and the reload register returns to all ones.
// The input register takes a request whenever it is empty or moves on, so while a
// result waits on m_axis_tready a new request is taken only into an empty register.
`timescale 1ns / 1ps

module input_capture_period_meter #(
  parameter int CHANNELS    = icpm_pkg::DEF_CHANNELS,
  parameter int COUNT_WIDTH = icpm_pkg::DEF_COUNT_WIDTH
) (
  input  logic         clk,
  input  logic         rst,
  // configuration
  input  logic         cfg_we,
  input  logic [31:0]  cfg_wdata,
  // requests
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [103:0] s_axis_tdata,  // capture_value[31:0], overcapture[32],
                                      // overflow_pending[33], counter_now[65:34],
                                      // time_ms[97:66], zero fill[103:98]
  input  logic [3:0]   s_axis_tuser,  // action[1:0], channel[3:2]
  // results
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [39:0]  m_axis_tdata,  // new_period[0], period_ticks[32:1],
                                      // channel_valid[33], capture_lost[34],
                                      // zero fill[39:35]
  output logic [1:0]   m_axis_tuser   // channel_out[1:0]
);

  logic [31:0]          reload;
  icpm_pkg::item_t      held_item;
  logic                 held_valid;
  icpm_pkg::res_t       result;
  logic                 result_valid;

  logic                 go;
  logic                 in_range;
  logic [31:0]          ovf_total;
  icpm_pkg::chan_rec_t  rec;
  icpm_pkg::dist_t      upd;
  icpm_pkg::res_t       res_next;

  // Reload register
  always_ff @(posedge clk) begin
    if (rst) begin
      reload <= icpm_pkg::RELOAD_RESET;
    end else if (cfg_we) begin
      reload <= cfg_wdata;
    end
  end

  // Handshake: the held request moves when the result slot frees up
  assign go            = held_valid && (!result_valid || m_axis_tready);
  assign s_axis_tready = !held_valid || go;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (s_axis_tready) begin
      held_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      held_item.action           <= icpm_pkg::action_t'(s_axis_tuser[1:0]);
      held_item.channel          <= s_axis_tuser[3:2];
      held_item.capture_value    <= s_axis_tdata[31:0];
      held_item.overcapture      <= s_axis_tdata[32];
      held_item.overflow_pending <= s_axis_tdata[33];
      held_item.counter_now      <= s_axis_tdata[65:34];
      held_item.time_ms          <= s_axis_tdata[97:66];
    end
  end

  // Distance and stamp logic
  icpm_dist #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dist (
    .reload    (reload),
    .ovf_total (ovf_total),
    .item      (held_item),
    .in_range  (in_range),
    .rec       (rec),
    .upd       (upd)
  );

  // Channel state
  icpm_state #(
    .CHANNELS (CHANNELS)
  ) u_state (
    .clk       (clk),
    .rst       (rst),
    .go        (go),
    .item      (held_item),
    .upd       (upd),
    .in_range  (in_range),
    .ovf_total (ovf_total),
    .rec       (rec),
    .res       (res_next)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (go) begin
      result_valid <= 1'b1;
    end else if (m_axis_tready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      result <= res_next;
    end
  end

  assign m_axis_tvalid = result_valid;
  assign m_axis_tuser  = result.channel_out;
  assign m_axis_tdata  = {5'd0, result.capture_lost, result.channel_valid,
                          result.period_ticks, result.new_period};

  // Checks
  a_clear_result: assert property (@(posedge clk) disable iff (rst)
    go && (held_item.action == icpm_pkg::ACT_CLEAR) |=>
      result_valid && !result.channel_valid && (result.period_ticks == 32'd0))
    else $error("clear request left a valid channel in its result");

  a_fresh_valid: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.new_period |->
      result.channel_valid && (result.period_ticks != 32'd0))
    else $error("fresh period reported without a valid nonzero period");

  a_lost_not_fresh: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.capture_lost |->
      !result.new_period && !result.channel_valid)
    else $error("lost capture reported with a period");

  a_held_kept: assert property (@(posedge clk) disable iff (rst)
    held_valid && !go |=> held_valid)
    else $error("held request dropped without moving on");

endmodule
